@@ src/bale_pkg.sv @@
// bale_pkg: shared types and constants for the bounded array list engine
// request and result words, request and status codes, cell control, states
// no dependencies
package bale_pkg;

	localparam int unsigned DEPTH_DEF = 64;

	typedef struct packed {
		logic [3:0]         req_type;
		logic signed [15:0] data_in;
		logic [5:0]         position;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [15:0] removed_value;
		logic [5:0]         found_index;
		logic [6:0]         list_length;
		logic signed [15:0] max_value;
		logic signed [15:0] min_value;
	} out_word_t;

	typedef enum logic [3:0] {
		REQ_CLEAR     = 4'd0,
		REQ_INS_FIRST = 4'd1,
		REQ_INS_AT    = 4'd2,
		REQ_INS_LAST  = 4'd3,
		REQ_DEL_FIRST = 4'd4,
		REQ_DEL_AT    = 4'd5,
		REQ_DEL_LAST  = 4'd6,
		REQ_SEARCH    = 4'd7,
		REQ_SORT_ASC  = 4'd8,
		REQ_SORT_DESC = 4'd9
	} req_t;

	localparam logic [2:0] STAT_OK     = 3'd0;
	localparam logic [2:0] STAT_FULL   = 3'd1;
	localparam logic [2:0] STAT_EMPTY  = 3'd2;
	localparam logic [2:0] STAT_BADIDX = 3'd3;
	localparam logic [2:0] STAT_MISS   = 3'd4;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_LOAD,
		CMD_FROM_PREV,
		CMD_FROM_NEXT,
		CMD_SORT_LEFT,
		CMD_SORT_RIGHT
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      ascending;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SORT,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

@@ src/bale_cell.sv @@
// bale_cell: one slot of the list chain, holds a single entry
// shifts from either neighbour, loads new data or does a compare-exchange
// depends on bale_pkg
module bale_cell (
	input  logic                clk,
	input  bale_pkg::cell_ctrl_t ctrl,
	input  logic signed [15:0]  data,
	input  logic signed [15:0]  prev_value,
	input  logic signed [15:0]  next_value,
	output logic signed [15:0]  value,
	output logic                match
);

	logic signed [15:0] value_q;
	logic signed [15:0] value_d;

	always_comb begin
		value_d = value_q;
		case (ctrl.cmd)
			bale_pkg::CMD_LOAD: value_d = data;
			bale_pkg::CMD_FROM_PREV: value_d = prev_value;
			bale_pkg::CMD_FROM_NEXT: value_d = next_value;
			// left of a pair keeps the smaller (ascending) value
			bale_pkg::CMD_SORT_LEFT: begin
				if (ctrl.ascending ? (value_q > next_value) : (value_q < next_value))
					value_d = next_value;
			end
			bale_pkg::CMD_SORT_RIGHT: begin
				if (ctrl.ascending ? (prev_value > value_q) : (prev_value < value_q))
					value_d = prev_value;
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;
	assign match = (value_q == data);

endmodule

@@ src/bounded_array_list_engine.sv @@
// Bounded array list engine. Holds up to DEPTH signed 16-bit entries in a
// chain of cells, one entry per cell. A request word is taken when the block
// is idle; the exec state decodes it and shifts the whole chain at once for
// inserts and deletes, and resolves searches through the match line of
// every cell. A sort then runs odd-even exchange passes across the chain,
// one pass a cycle, as many passes as there are entries but at least one.
// Every request ends with a scan of the live entries for maximum and
// minimum, one cell a cycle.
// A result word may wait at the output while the next request is taken.
// top level, depends on bale_pkg and bale_cell
module bounded_array_list_engine #(
	parameter int unsigned DEPTH = bale_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bale_pkg::in_word_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bale_pkg::out_word_t rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = $clog2(DEPTH);

	bale_pkg::state_t    state_q, state_d;
	bale_pkg::in_word_t  req_q;
	bale_pkg::out_word_t rsp_q;
	logic                rsp_valid_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       pass_q;
	logic [CW-1:0]       idx_q;
	logic                asc_q;
	logic [2:0]          status_q;
	logic signed [15:0]  removed_q;
	logic [5:0]          found_q;
	logic signed [15:0]  max_q, min_q;

	logic signed [15:0]  cell_val [DEPTH];
	logic [DEPTH-1:0]    cell_match;
	bale_pkg::cell_ctrl_t cell_ctrl [DEPTH];

	// request decode
	logic [2:0]    dec_status;
	logic          dec_ins, dec_del, dec_search;
	logic [CW-1:0] dec_at, dec_count;
	logic          full, empty;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		dec_status = bale_pkg::STAT_OK;
		dec_ins    = 1'b0;
		dec_del    = 1'b0;
		dec_search = 1'b0;
		dec_at     = '0;
		dec_count  = count_q;
		case (bale_pkg::req_t'(req_q.req_type))
			bale_pkg::REQ_CLEAR: dec_count = '0;
			bale_pkg::REQ_INS_FIRST, bale_pkg::REQ_INS_LAST: begin
				if (full) begin
					dec_status = bale_pkg::STAT_FULL;
				end else begin
					dec_ins   = 1'b1;
					dec_at    = (req_q.req_type == bale_pkg::REQ_INS_FIRST) ? '0 : count_q;
					dec_count = count_q + 1'b1;
				end
			end
			bale_pkg::REQ_INS_AT: begin
				if (empty || full) begin
					dec_status = bale_pkg::STAT_FULL;
				end else if (32'(req_q.position) > 32'(count_q)) begin
					dec_status = bale_pkg::STAT_BADIDX;
				end else begin
					dec_ins   = 1'b1;
					dec_at    = CW'(req_q.position);
					dec_count = count_q + 1'b1;
				end
			end
			bale_pkg::REQ_DEL_FIRST, bale_pkg::REQ_DEL_LAST: begin
				if (empty) begin
					dec_status = bale_pkg::STAT_EMPTY;
				end else begin
					dec_del   = 1'b1;
					dec_at    = (req_q.req_type == bale_pkg::REQ_DEL_FIRST) ? '0
						: count_q - 1'b1;
					dec_count = count_q - 1'b1;
				end
			end
			bale_pkg::REQ_DEL_AT: begin
				if (empty) begin
					dec_status = bale_pkg::STAT_EMPTY;
				end else if (32'(req_q.position) >= 32'(count_q)) begin
					dec_status = bale_pkg::STAT_BADIDX;
				end else begin
					dec_del   = 1'b1;
					dec_at    = CW'(req_q.position);
					dec_count = count_q - 1'b1;
				end
			end
			bale_pkg::REQ_SEARCH: dec_search = 1'b1;
			bale_pkg::REQ_SORT_ASC, bale_pkg::REQ_SORT_DESC: dec_status = bale_pkg::STAT_OK;
			default: dec_status = bale_pkg::STAT_FULL;
		endcase
	end

	// lowest live cell that matches
	logic       hit;
	logic [5:0] hit_idx;

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_match[i] && (CW'(i) < count_q)) begin
				hit     = 1'b1;
				hit_idx = 6'(i);
			end
		end
	end

	// the chain
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		always_comb begin
			cell_ctrl[g].cmd       = bale_pkg::CMD_HOLD;
			cell_ctrl[g].ascending = asc_q;
			if (state_q == bale_pkg::S_EXEC && dec_ins) begin
				if (CW'(g) == dec_at)
					cell_ctrl[g].cmd = bale_pkg::CMD_LOAD;
				else if (CW'(g) > dec_at)
					cell_ctrl[g].cmd = bale_pkg::CMD_FROM_PREV;
			end else if (state_q == bale_pkg::S_EXEC && dec_del) begin
				if (CW'(g) >= dec_at)
					cell_ctrl[g].cmd = bale_pkg::CMD_FROM_NEXT;
			end else if (state_q == bale_pkg::S_SORT) begin
				// pairs start on even cells in even passes, odd cells in odd ones
				if ((1'(g % 2) == pass_q[0]) && (CW'(g + 1) < count_q))
					cell_ctrl[g].cmd = bale_pkg::CMD_SORT_LEFT;
				else if ((g > 0) && (1'((g + 1) % 2) == pass_q[0]) && (CW'(g) < count_q))
					cell_ctrl[g].cmd = bale_pkg::CMD_SORT_RIGHT;
			end
		end

		bale_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl[g]),
			.data       (req_q.data_in),
			.prev_value (cell_val[(g == 0) ? 0 : g - 1]),
			.next_value (cell_val[(g == DEPTH - 1) ? g : g + 1]),
			.value      (cell_val[g]),
			.match      (cell_match[g])
		);
	end

	logic sort_req;
	logic pass_last, scan_last;
	logic rsp_free;

	assign sort_req  = (req_q.req_type == bale_pkg::REQ_SORT_ASC)
		|| (req_q.req_type == bale_pkg::REQ_SORT_DESC);
	assign pass_last = ({1'b0, pass_q} + 1'b1) >= {1'b0, count_q};
	assign scan_last = empty || (({1'b0, idx_q} + 1'b1) >= {1'b0, count_q});
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bale_pkg::S_IDLE: if (req_valid) state_d = bale_pkg::S_EXEC;
			bale_pkg::S_EXEC: state_d = sort_req ? bale_pkg::S_SORT : bale_pkg::S_SCAN;
			bale_pkg::S_SORT: if (pass_last) state_d = bale_pkg::S_SCAN;
			bale_pkg::S_SCAN: if (scan_last) state_d = bale_pkg::S_DONE;
			bale_pkg::S_DONE: if (rsp_free) state_d = bale_pkg::S_IDLE;
			default: state_d = bale_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall = (state_q != bale_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bale_pkg::S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bale_pkg::S_EXEC)
				count_q <= dec_count;
			if (state_q == bale_pkg::S_DONE && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	logic signed [15:0] scan_val;
	assign scan_val = cell_val[idx_q[IW-1:0]];

	always_ff @(posedge clk) begin
		case (state_q)
			bale_pkg::S_IDLE: begin
				if (req_valid)
					req_q <= req;
			end
			bale_pkg::S_EXEC: begin
				status_q  <= dec_search ? (hit ? bale_pkg::STAT_OK : bale_pkg::STAT_MISS)
					: dec_status;
				removed_q <= dec_del ? cell_val[dec_at[IW-1:0]] : '0;
				found_q   <= (dec_search && hit) ? hit_idx : '0;
				asc_q     <= (req_q.req_type == bale_pkg::REQ_SORT_ASC);
				pass_q    <= '0;
				idx_q     <= '0;
			end
			bale_pkg::S_SORT: pass_q <= pass_q + 1'b1;
			bale_pkg::S_SCAN: begin
				if (empty) begin
					max_q <= '0;
					min_q <= '0;
				end else if (idx_q == '0) begin
					max_q <= scan_val;
					min_q <= scan_val;
				end else begin
					if (scan_val > max_q) max_q <= scan_val;
					if (scan_val < min_q) min_q <= scan_val;
				end
				idx_q <= idx_q + 1'b1;
			end
			bale_pkg::S_DONE: begin
				if (rsp_free) begin
					rsp_q.status        <= status_q;
					rsp_q.removed_value <= removed_q;
					rsp_q.found_index   <= found_q;
					rsp_q.list_length   <= 7'(count_q);
					rsp_q.max_value     <= max_q;
					rsp_q.min_value     <= min_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ src/bale_checker.sv @@
// bale_assertions: port-level checks on the list engine's result channel
// bound to bounded_array_list_engine, depends on bale_pkg
module bale_assertions #(
	parameter int unsigned DEPTH = bale_pkg::DEPTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input bale_pkg::out_word_t rsp
);

	// a stalled word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result word dropped or changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.list_length) <= DEPTH)
		else $error("list length beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.list_length == '0 |-> rsp.max_value == '0 && rsp.min_value == '0)
		else $error("empty list reports nonzero extremes");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.list_length != '0 |-> rsp.max_value >= rsp.min_value)
		else $error("maximum below minimum");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bale_pkg::STAT_OK && rsp.status != bale_pkg::STAT_MISS
		|-> rsp.found_index == '0)
		else $error("found index set without a search hit");

endmodule

bind bounded_array_list_engine bale_assertions #(.DEPTH(DEPTH)) u_bale_assertions (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
